// File: rtl/core/atrm_pkg.sv
package atrm_pkg;

  localparam int NUM_PATTERNS  = 4;
  localparam int PATTERN_CHARS = 8;
  localparam int LINE_DEPTH    = 64;

  localparam int PAT_REGS  = 4;
  localparam int NPAT      = (NUM_PATTERNS < PAT_REGS) ? NUM_PATTERNS : PAT_REGS;
  localparam int POS_W     = $clog2(PATTERN_CHARS + 1);
  localparam int CHI_W     = (PATTERN_CHARS > 1) ? $clog2(PATTERN_CHARS) : 1;
  localparam int CNT_W     = $clog2(LINE_DEPTH);
  localparam int LEN_W     = 6;
  localparam int PAT_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 64;

  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_NUL = 8'h00;

  localparam logic [CFG_IDX_W-1:0] REG_PAT_LAST = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MODES    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PERM     = 3'd6;

  localparam logic [1:0] MODE_LINE  = 2'd1;
  localparam logic [1:0] MODE_MULTI = 2'd2;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_BYTE  = 2'd1;
  localparam logic [1:0] KIND_EVENT = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEND_FIRST,
    ST_SEND_SECOND
  } ctrl_state_t;

  typedef struct packed {
    logic step;
    logic second;
  } dp_cmd_t;

  typedef struct packed {
    logic two;
  } dp_status_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [1:0]       idx;
    logic [7:0]       data;
    logic [LEN_W-1:0] len;
  } result_t;

  function automatic logic [LEN_W-1:0] to_len(input logic [CNT_W-1:0] cnt);
    logic [LEN_W+CNT_W-1:0] wide;
    wide = {{LEN_W{1'b0}}, cnt};
    return wide[LEN_W-1:0];
  endfunction

endpackage

// File: rtl/core/atrm_ctrl.sv
module atrm_ctrl
  import atrm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd.step   = 1'b0;
    cmd.second = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.step  = 1'b1;
          state_nxt = ST_SEND_FIRST;
        end
      end
      ST_SEND_FIRST: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = status.two ? ST_SEND_SECOND : ST_IDLE;
        end
      end
      ST_SEND_SECOND: begin
        out_valid  = 1'b1;
        cmd.second = 1'b1;
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/atrm_datapath.sv
module atrm_datapath
  import atrm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic [7:0]           in_rx_byte,
  input  dp_cmd_t              cmd,
  output dp_status_t           status,
  output logic [1:0]           out_kind,
  output logic [1:0]           out_pattern_index,
  output logic [7:0]           out_data_byte,
  output logic [LEN_W-1:0]     out_line_length,
  output logic                 out_locked,
  output logic                 out_last
);

  logic [PAT_W-1:0] pat_r [PAT_REGS];
  logic [7:0]       modes_r;
  logic [2:0]       active_r;
  logic [2:0]       perm_r;

  logic [POS_W-1:0] pos_r [NPAT];
  logic [POS_W-1:0] pos_nxt [NPAT];
  logic             cap_r, cap_nxt;
  logic [1:0]       cap_pat_r, cap_pat_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             lock_r, lock_nxt;

  result_t          res0_r, res0_nxt;
  result_t          res1_r, res1_nxt;
  logic             two_r, two_nxt;

  logic [POS_W-1:0] plen [NPAT];
  logic [2:0]       act;
  logic [2:0]       act_new;
  logic [NPAT-1:0]  arm_clr;

  logic [1:0]       p;
  logic [1:0]       mode;
  logic             eol;
  logic             ended;
  logic             emit_b;
  logic [CNT_W-1:0] cnt_run;
  logic [LEN_W-1:0] ev_len;
  logic [2:0]       first;
  logic             scan;
  logic             done;
  logic [7:0]       ch;

  always_comb begin
    for (int i = 0; i < NPAT; i++) begin
      logic found;
      found   = 1'b0;
      plen[i] = POS_W'(PATTERN_CHARS);
      for (int k = 0; k < PATTERN_CHARS; k++) begin
        if (!found && pat_r[i][8*k +: 8] == CH_NUL) begin
          found   = 1'b1;
          plen[i] = POS_W'(k);
        end
      end
    end
  end

  assign act     = (active_r > 3'(NPAT)) ? 3'(NPAT) : active_r;
  assign act_new = (cfg_wdata[2:0] > 3'(NPAT)) ? 3'(NPAT) : cfg_wdata[2:0];

  always_comb begin
    for (int i = 0; i < NPAT; i++) begin
      arm_clr[i] = cfg_we && cfg_index == REG_ACTIVE && 3'(i) >= act && 3'(i) < act_new;
    end
  end

  always_comb begin
    p       = cap_pat_r;
    mode    = modes_r[{p, 1'b0} +: 2];
    eol     = in_rx_byte == CH_CR || in_rx_byte == CH_LF;
    ended   = 1'b0;
    emit_b  = 1'b0;
    cnt_run = cnt_r;
    if (cap_r) begin
      case (mode)
        MODE_LINE: begin
          if (eol) begin
            ended = 1'b1;
          end else if (cnt_r < CNT_W'(LINE_DEPTH - 1)) begin
            cnt_run = cnt_r + CNT_W'(1);
            emit_b  = 1'b1;
          end
        end
        MODE_MULTI: begin
          if (!eol) begin
            cnt_run = cnt_r + CNT_W'(1);
            emit_b  = 1'b1;
            ended   = cnt_r >= CNT_W'(LINE_DEPTH - 2) || in_rx_byte == CH_NUL;
          end
        end
        default: begin
          ended = 1'b1;
        end
      endcase
    end
    ev_len = (mode == MODE_LINE || mode == MODE_MULTI) ? to_len(cnt_run) : '0;
    first  = ended ? ({1'b0, p} + 3'd1) : 3'd0;
    scan   = !cap_r || ended;

    cap_nxt     = cap_r && !ended;
    cap_pat_nxt = cap_pat_r;
    cnt_nxt     = cnt_run;
    lock_nxt    = ended ? 1'b0 : lock_r;
    done        = 1'b0;
    ch          = 8'h00;
    for (int i = 0; i < NPAT; i++) begin
      pos_nxt[i] = pos_r[i];
      if (scan && !done && 3'(i) >= first && 3'(i) < act) begin
        ch = pat_r[i][{pos_r[i][CHI_W-1:0], 3'b000} +: 8];
        if (pos_r[i] < plen[i] && in_rx_byte == ch) begin
          pos_nxt[i] = pos_r[i] + POS_W'(1);
          if (pos_nxt[i] == plen[i]) begin
            cap_nxt     = 1'b1;
            cap_pat_nxt = 2'(i);
            cnt_nxt     = '0;
            lock_nxt    = 3'(i) < perm_r;
            done        = 1'b1;
          end
        end else begin
          pos_nxt[i] = '0;
        end
      end
    end

    res0_nxt = '{kind: KIND_NONE, idx: 2'd0, data: 8'h00, len: '0};
    res1_nxt = '{kind: KIND_EVENT, idx: p, data: 8'h00, len: ev_len};
    if (emit_b) begin
      res0_nxt = '{kind: KIND_BYTE, idx: p, data: in_rx_byte, len: to_len(cnt_run)};
    end else if (ended) begin
      res0_nxt = res1_nxt;
    end
    two_nxt = emit_b && ended;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PAT_REGS; i++) begin
        pat_r[i] <= '0;
      end
      for (int i = 0; i < NPAT; i++) begin
        pos_r[i] <= '0;
      end
      modes_r   <= '0;
      active_r  <= '0;
      perm_r    <= '0;
      cap_r     <= 1'b0;
      cap_pat_r <= '0;
      cnt_r     <= '0;
      lock_r    <= 1'b0;
      two_r     <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index <= REG_PAT_LAST) begin
        pat_r[cfg_index[1:0]] <= cfg_wdata;
      end else if (cfg_index == REG_MODES) begin
        modes_r <= cfg_wdata[7:0];
      end else if (cfg_index == REG_ACTIVE) begin
        active_r <= cfg_wdata[2:0];
      end else if (cfg_index == REG_PERM) begin
        perm_r <= cfg_wdata[2:0];
      end
      for (int i = 0; i < NPAT; i++) begin
        if (arm_clr[i]) begin
          pos_r[i] <= '0;
        end
      end
    end else if (cmd.step) begin
      for (int i = 0; i < NPAT; i++) begin
        pos_r[i] <= pos_nxt[i];
      end
      cap_r     <= cap_nxt;
      cap_pat_r <= cap_pat_nxt;
      cnt_r     <= cnt_nxt;
      lock_r    <= lock_nxt;
      two_r     <= two_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      res0_r <= res0_nxt;
      res1_r <= res1_nxt;
    end
  end

  assign status.two = two_r;

  always_comb begin
    if (cmd.second) begin
      out_kind          = res1_r.kind;
      out_pattern_index = res1_r.idx;
      out_data_byte     = res1_r.data;
      out_line_length   = res1_r.len;
      out_last          = 1'b1;
    end else begin
      out_kind          = res0_r.kind;
      out_pattern_index = res0_r.idx;
      out_data_byte     = res0_r.data;
      out_line_length   = res0_r.len;
      out_last          = !two_r;
    end
    out_locked = lock_r;
  end

endmodule

// File: rtl/core/at_response_matcher.sv
// Matches received modem bytes against up to four response patterns and
// captures what follows a match.
// Input channel: in_valid / in_ready carry one received byte (in_rx_byte).
// Result channel: out_valid / out_ready carry one result per item: kind,
// pattern index, captured byte, line length, lock flag and a last marker
// on the final result belonging to the byte.
// Each byte yields one result, or two when a multi-line capture emits its
// final byte and its completion event together.
// Latency: the first result is valid the cycle after the byte is taken.
// The controller takes a new byte only once every result of the previous
// one has gone, since the match and capture state of each byte depends on
// the last.
// All comparisons and the priority selection over the patterns run in the
// cycle in which the byte is taken, and their results are registered then.
// Configuration: cfg_we, cfg_index and cfg_wdata write one register per
// cycle; write only while no byte is in flight.
// Reset clears the patterns, modes, counts, match positions and any capture.
// A stalled receiver holds the current result; no byte is taken meanwhile.
module at_response_matcher
  import atrm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_rx_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_kind,
  output logic [1:0]           out_pattern_index,
  output logic [7:0]           out_data_byte,
  output logic [LEN_W-1:0]     out_line_length,
  output logic                 out_locked,
  output logic                 out_last
);

  dp_cmd_t    cmd;
  dp_status_t status;

  atrm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  atrm_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_rx_byte        (in_rx_byte),
    .cmd               (cmd),
    .status            (status),
    .out_kind          (out_kind),
    .out_pattern_index (out_pattern_index),
    .out_data_byte     (out_data_byte),
    .out_line_length   (out_line_length),
    .out_locked        (out_locked),
    .out_last          (out_last)
  );

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import atrm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_PAT_FIRST = REG_PAT_LAST - 3'd3;
  localparam logic [1:0] MODE_SIMPLE = 2'd0;
  localparam int CYCLE_LIMIT = 500000;
  localparam int ITEMS_PER_PHASE = 435;
  localparam int MAX_REPORTS = 100;

  typedef struct packed {
    logic [1:0]       kind;
    logic [1:0]       pat;
    logic [7:0]       data;
    logic [LEN_W-1:0] len;
    logic             locked;
    logic             last;
  } match_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic [7:0]           in_rx_byte = '0;
  logic                 out_ready = 1'b0;
  logic                 in_ready;
  logic                 out_valid;
  logic [1:0]           out_kind;
  logic [1:0]           out_pattern_index;
  logic [7:0]           out_data_byte;
  logic [LEN_W-1:0]     out_line_length;
  logic                 out_locked;
  logic                 out_last;

  // matcher state as the predictor sees it
  logic [63:0] pat_text [4];
  logic [7:0]  cap_modes;
  logic [2:0]  act_cnt;
  logic [2:0]  perm_cnt;
  logic [3:0]  mpos [4];
  logic        cap_on;
  int          cap_pat;
  int          cap_cnt;
  logic        lock;

  match_result_t awaited_results[$];
  string word_chars = "OK+CSQ:RINGERROR 0123456789,";
  string pat_chars = "OKRIN+:";

  int send_idle = 0;
  int out_stall = 0;
  int items_sent = 0;
  int results_checked = 0;
  int bytes_seen = 0;
  int events_seen = 0;
  int reg_writes = 0;
  int errors = 0;
  int cycle_count = 0;

  at_response_matcher DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_pattern_index (out_pattern_index),
    .out_data_byte     (out_data_byte),
    .out_line_length   (out_line_length),
    .out_locked        (out_locked),
    .out_last          (out_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** at_response_matcher: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= out_stall);
  end

  always @(posedge clk) begin
    match_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result: kind %0d pattern %0d data %02h len %0d lock %0b last %0b",
                   $time, out_kind, out_pattern_index, out_data_byte, out_line_length,
                   out_locked, out_last);
      end else begin
        want = awaited_results.pop_front();
        results_checked++;
        if (want.kind == KIND_BYTE) bytes_seen++;
        if (want.kind == KIND_EVENT) events_seen++;
        if (out_kind !== want.kind || out_pattern_index !== want.pat ||
            out_data_byte !== want.data || out_line_length !== want.len ||
            out_locked !== want.locked || out_last !== want.last) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: mismatch: expected kind %0d pattern %0d data %02h len %0d lock %0b last %0b, got kind %0d pattern %0d data %02h len %0d lock %0b last %0b",
                     $time, want.kind, want.pat, want.data, want.len, want.locked, want.last,
                     out_kind, out_pattern_index, out_data_byte, out_line_length,
                     out_locked, out_last);
        end
      end
    end
  end

  function automatic int armed_patterns();
    int n;
    n = act_cnt;
    if (n > NPAT) n = NPAT;
    return n;
  endfunction

  function automatic int pattern_length(input logic [63:0] w);
    int k;
    for (k = 0; k < PATTERN_CHARS; k++)
      if (w[8*k +: 8] == CH_NUL) return k;
    return k;
  endfunction

  // work out the results of one byte and advance the matcher state
  task automatic match_byte(input logic [7:0] c);
    match_result_t found[$];
    logic [1:0] mode;
    logic ended;
    logic eol;
    logic hit;
    int from;
    int n_arm;
    int plen;
    int pos;
    from = 0;
    if (cap_on) begin
      mode = cap_modes[2*cap_pat +: 2];
      ended = 1'b0;
      eol = (c == CH_CR || c == CH_LF);
      if (mode == MODE_LINE) begin
        if (eol) ended = 1'b1;
        else if (cap_cnt < LINE_DEPTH - 1) begin
          cap_cnt++;
          found.push_back('{KIND_BYTE, 2'(cap_pat), c, LEN_W'(cap_cnt), 1'b0, 1'b0});
        end
      end else if (mode == MODE_MULTI) begin
        if (!eol) begin
          cap_cnt++;
          found.push_back('{KIND_BYTE, 2'(cap_pat), c, LEN_W'(cap_cnt), 1'b0, 1'b0});
          if (cap_cnt >= LINE_DEPTH - 1 || c == CH_NUL) ended = 1'b1;
        end
      end else begin
        ended = 1'b1;
      end
      if (ended) begin
        found.push_back('{KIND_EVENT, 2'(cap_pat), 8'h00,
                          (mode == MODE_LINE || mode == MODE_MULTI) ? LEN_W'(cap_cnt) : '0,
                          1'b0, 1'b0});
        cap_on = 1'b0;
        lock = 1'b0;
        from = cap_pat + 1;
      end
    end
    if (!cap_on) begin
      n_arm = armed_patterns();
      hit = 1'b0;
      for (int i = from; i < n_arm && !hit; i++) begin
        plen = pattern_length(pat_text[i]);
        pos = mpos[i];
        if (pos < plen && c == pat_text[i][8*pos +: 8]) begin
          pos++;
          mpos[i] = 4'(pos);
          if (pos == plen) begin
            hit = 1'b1;
            cap_on = 1'b1;
            cap_pat = i;
            cap_cnt = 0;
            lock = (i < perm_cnt);
          end
        end else begin
          mpos[i] = '0;
        end
      end
    end
    if (found.size() == 0) found.push_back('{KIND_NONE, 2'd0, 8'h00, '0, 1'b0, 1'b0});
    foreach (found[k]) begin
      found[k].locked = lock;
      found[k].last = (k == found.size() - 1);
      awaited_results.push_back(found[k]);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
    int was;
    int now_armed;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    case (idx)
      REG_MODES: cap_modes = v[7:0];
      REG_ACTIVE: begin
        was = armed_patterns();
        act_cnt = v[2:0];
        now_armed = armed_patterns();
        for (int i = was; i < now_armed; i++) mpos[i] = '0;
      end
      REG_PERM: perm_cnt = v[2:0];
      default: if (idx <= REG_PAT_LAST) pat_text[idx - REG_PAT_FIRST] = v;
    endcase
    reg_writes++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // hold the sender until every awaited result has come out
  task automatic settle();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    match_byte(b);
    items_sent++;
    if (send_idle > 0 && $urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [63:0] pattern_word(input string s);
    logic [63:0] w;
    w = '0;
    for (int i = 0; i < s.len() && i < 8; i++) w[8*i +: 8] = s[i];
    return w;
  endfunction

  function automatic logic [63:0] random_pattern();
    logic [63:0] w;
    int r;
    int len;
    r = $urandom_range(0, 11);
    w = {$urandom, $urandom};
    if (r == 0) w = '0;
    else if (r == 1) w = '1;
    else if (r > 2) begin
      len = (r < 9) ? $urandom_range(1, 4) : $urandom_range(5, 8);
      for (int k = 0; k < len; k++) w[8*k +: 8] = pat_chars[$urandom_range(0, pat_chars.len() - 1)];
      if (len < 8) w[8*len +: 8] = CH_NUL;
    end
    return w;
  endfunction

  function automatic logic [7:0] payload_byte();
    int r;
    r = $urandom_range(0, 19);
    case (r)
      0: return CH_CR;
      1: return CH_LF;
      2: return CH_NUL;
      default: begin
        if (r < 10) return 8'($urandom_range(0, 255));
        return word_chars[$urandom_range(0, word_chars.len() - 1)];
      end
    endcase
  endfunction

  task automatic random_setup();
    for (int i = 0; i < 4; i++) write_reg(REG_PAT_FIRST + 3'(i), random_pattern());
    write_reg(REG_MODES, ($urandom_range(0, 7) == 0) ? 64'hFF : 64'($urandom_range(0, 255)));
    write_reg(REG_ACTIVE, ($urandom_range(0, 2) == 0) ? 64'($urandom_range(0, 7)) : 64'd4);
    write_reg(REG_PERM, 64'($urandom_range(0, 7)));
  endtask

  task automatic retune_register();
    case ($urandom_range(0, 3))
      0: write_reg(REG_MODES, 64'($urandom_range(0, 255)));
      1: write_reg(REG_ACTIVE, 64'($urandom_range(0, 7)));
      2: write_reg(REG_PERM, 64'($urandom_range(0, 7)));
      default: write_reg(REG_PAT_FIRST + 3'($urandom_range(0, 3)), random_pattern());
    endcase
  endtask

  // pattern text followed by a line of random content
  task automatic send_framed();
    int p;
    int len;
    int n;
    logic long_line;
    p = $urandom_range(0, 3);
    len = pattern_length(pat_text[p]);
    for (int k = 0; k < len; k++) send_byte(pat_text[p][8*k +: 8]);
    if (len == 0) send_byte(payload_byte());
    long_line = ($urandom_range(0, 15) == 0);
    n = long_line ? $urandom_range(60, 70) : $urandom_range(0, 6);
    for (int k = 0; k < n; k++)
      send_byte(long_line ? word_chars[$urandom_range(0, word_chars.len() - 1)] : payload_byte());
    case ($urandom_range(0, 3))
      0: send_byte(CH_CR);
      1: send_byte(CH_LF);
      2: send_byte(CH_NUL);
      default: begin
        send_byte(CH_CR);
        send_byte(CH_LF);
      end
    endcase
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 6);
    for (int k = 0; k < n; k++) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic run_traffic(input int idle_pct, input int stall_pct);
    int stop_at;
    int r;
    settle();
    send_idle = idle_pct;
    out_stall = stall_pct;
    random_setup();
    stop_at = items_sent + ITEMS_PER_PHASE;
    while (items_sent < stop_at) begin
      r = $urandom_range(0, 19);
      if (r < 13) send_framed();
      else if (r < 19) send_noise();
      else begin
        settle();
        if ($urandom_range(0, 3) == 0) random_setup();
        else retune_register();
      end
    end
  endtask

  task automatic test_reset_state();
    send_byte(CH_NUL);
    send_byte(8'hFF);
    send_text("O");
  endtask

  task automatic test_directed_cases();
    settle();
    write_reg(REG_PAT_FIRST, pattern_word("OK"));
    write_reg(REG_PAT_FIRST + 3'd1, pattern_word("+C"));
    write_reg(REG_PAT_FIRST + 3'd2, pattern_word("RI"));
    write_reg(REG_PAT_LAST, 64'hEEEE_EEEE_EE00_5441);
    write_reg(REG_MODES, 64'({MODE_SIMPLE, MODE_MULTI, MODE_LINE, MODE_SIMPLE}));
    write_reg(REG_ACTIVE, 64'd7);
    write_reg(REG_PERM, 64'd2);
    // ending byte of one capture starts the next pattern
    send_text("OK+C7");
    send_byte(CH_LF);
    send_text("RIa");
    send_byte(CH_NUL);
    // mode change during a capture
    send_text("RI");
    settle();
    write_reg(REG_MODES, 64'({MODE_SIMPLE, MODE_LINE, MODE_LINE, MODE_SIMPLE}));
    send_text("z");
    send_byte(CH_CR);
    // disarm while a capture runs
    send_text("+C");
    settle();
    write_reg(REG_ACTIVE, 64'd1);
    send_text("a");
    send_byte(CH_LF);
  endtask

  task automatic test_no_idling();
    run_traffic(0, 0);
  endtask

  task automatic test_sender_idle();
    run_traffic(69, 0);
  endtask

  task automatic test_receiver_stall();
    run_traffic(0, 69);
  endtask

  task automatic test_both_idle();
    run_traffic(9, 9);
  endtask

  initial begin
    for (int i = 0; i < 4; i++) begin
      pat_text[i] = '0;
      mpos[i] = '0;
    end
    cap_modes = '0;
    act_cnt = '0;
    perm_cnt = '0;
    cap_on = 1'b0;
    cap_pat = 0;
    cap_cnt = 0;
    lock = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_directed_cases();
    test_no_idling();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    settle();
    repeat (10) @(posedge clk);
    $display("Sent %0d received bytes; checked %0d results (%0d captured bytes, %0d events).",
             items_sent, results_checked, bytes_seen, events_seen);
    $display("Made %0d register writes across four idling phases; %0d failures.",
             reg_writes, errors);
    if (errors == 0 && awaited_results.size() == 0) begin
      $display("** at_response_matcher: PASSED **");
    end else begin
      $display("** at_response_matcher: FAILED **");
    end
    $finish;
  end

endmodule
